// ===== rtl/coarse_tile_passability_map_core_defines.svh =====
// Assertion macros for the coarse tile passability map core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef COARSE_TILE_PASSABILITY_MAP_CORE_DEFINES_SVH
`define COARSE_TILE_PASSABILITY_MAP_CORE_DEFINES_SVH
`ifndef SYNTH
`define CPTM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CPTM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CPTM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CPTM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/cptm_pkg.sv =====
// Shared constants, command/status types and the reciprocal table for the tile map.
// No dependencies.
`timescale 1ns / 1ps
package cptm_pkg;

  localparam int MAX_GRID_DIM  = 256;
  localparam int MAX_TILE_SIDE = 8;
  localparam int COORD_W       = $clog2(MAX_GRID_DIM);
  localparam int DIM_W         = COORD_W + 1;
  localparam int TS_W          = 4;
  localparam int IN_W          = 10;
  localparam int RCP_SH        = 12;
  localparam int RCP_W         = RCP_SH + 1;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 9;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_PREDICT = 3'd1;
  localparam logic [2:0] OP_QUERY   = 3'd2;
  localparam logic [2:0] OP_NBR     = 3'd3;
  localparam logic [2:0] OP_LIST    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE   = 2'd2;

  typedef enum logic [1:0] {RD_CELL, RD_UP, RD_MID, RD_DN} rsel_t;
  typedef enum logic [1:0] {CAP_UP, CAP_MID, CAP_DN} csel_t;
  typedef enum logic [1:0] {OUT_QUERY, OUT_NBR, OUT_LIST} okind_t;

  typedef struct packed {
    logic [DIM_W-1:0] gw;
    logic [DIM_W-1:0] gh;
    logic [TS_W-1:0]  ts;
    logic [RCP_W-1:0] rcp;
  } geom_t;

  typedef struct packed {
    logic   latch;
    logic   calc;
    logic   rd_en;
    rsel_t  rd_sel;
    logic   wr_en;
    logic   cap_en;
    csel_t  cap_sel;
    logic   list_init;
    logic   out_load;
    okind_t out_kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       blocked;
    logic       cell_in;
    logic       tile_in;
    logic       out_free;
    logic       list_last;
  } stat_t;

  // ceil(2^RCP_SH / ts): exact floor division of any 9-bit value by ts
  function automatic logic [RCP_W-1:0] tile_rcp(input logic [TS_W-1:0] ts);
    logic [RCP_W-1:0] r;
    case (ts)
      4'd1:    r = 13'd4096;
      4'd2:    r = 13'd2048;
      4'd3:    r = 13'd1366;
      4'd4:    r = 13'd1024;
      4'd5:    r = 13'd820;
      4'd6:    r = 13'd683;
      4'd7:    r = 13'd586;
      4'd8:    r = 13'd512;
      default: r = 13'd4096;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cptm_ctrl.sv =====
// Sequencing state machine for the tile map: issues datapath commands per item.
// Depends on cptm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "coarse_tile_passability_map_core_defines.svh"
module cptm_ctrl import cptm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CALC, S_DEC, S_RD0, S_RD1, S_RD2, S_CAP, S_WR, S_EMIT, S_LINIT, S_LIST
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = rst || (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.latch  = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        unique case (stat.op)
          OP_LOAD:    state_next = (stat.cell_in && !stat.blocked) ? S_RD0 : S_IDLE;
          OP_PREDICT: state_next = stat.cell_in ? S_RD0 : S_IDLE;
          OP_QUERY:   state_next = stat.tile_in ? S_RD0 : S_EMIT;
          OP_NBR:     state_next = S_RD0;
          OP_LIST:    state_next = stat.tile_in ? S_LINIT : S_IDLE;
          default:    state_next = S_IDLE;
        endcase
      end
      S_RD0: begin
        cmd.rd_en = 1'b1;
        unique case (stat.op) inside
          OP_LOAD, OP_PREDICT: begin
            cmd.rd_sel = RD_CELL;
            state_next = S_WR;
          end
          OP_QUERY: begin
            cmd.rd_sel = RD_MID;
            state_next = S_CAP;
          end
          default: begin
            cmd.rd_sel = RD_UP;
            state_next = S_RD1;
          end
        endcase
      end
      S_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_MID;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CAP_UP;
        state_next  = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_DN;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CAP_MID;
        state_next  = S_CAP;
      end
      S_CAP: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = (stat.op == OP_NBR) ? CAP_DN : CAP_MID;
        state_next  = S_EMIT;
      end
      S_WR: begin
        cmd.wr_en  = 1'b1;
        state_next = S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = (stat.op == OP_NBR) ? OUT_NBR : OUT_QUERY;
          state_next   = S_IDLE;
        end
      end
      S_LINIT: begin
        cmd.list_init = 1'b1;
        state_next    = S_LIST;
      end
      S_LIST: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_LIST;
          if (stat.list_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `CPTM_ASSERT_IMP(a_wr_op, clk, rst, cmd.wr_en, stat.op == OP_LOAD || stat.op == OP_PREDICT)
  `CPTM_ASSERT_IMP(a_wr_in_grid, clk, rst, cmd.wr_en, stat.cell_in)
  `CPTM_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, stat.out_free)
  `CPTM_ASSERT_NXT(a_list_done, clk, rst,
                   state == S_LIST && cmd.out_load && stat.list_last, state == S_IDLE)

endmodule

// ===== rtl/cptm_dp.sv =====
// Datapath for the tile map: item registers, divide-by-reciprocal, tile row memory,
// neighbour capture, list counters and the result register. Depends on cptm_pkg.
`timescale 1ns / 1ps
module cptm_dp import cptm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  geom_t                  geom,
  input  logic [2:0]             op,
  input  logic signed [IN_W-1:0] x,
  input  logic signed [IN_W-1:0] y,
  input  logic                   cell_blocked,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic                   passable,
  output logic [3:0]             neighbor_mask,
  output logic [COORD_W-1:0]     cell_x_out,
  output logic [COORD_W-1:0]     cell_y_out,
  output logic                   last
);

  localparam int PROD_W = DIM_W + RCP_W;
  localparam int LP_W   = DIM_W + TS_W;

  function automatic logic in_rng(input logic [IN_W:0] v, input logic [DIM_W-1:0] lim);
    return !v[IN_W] && (v[IN_W-1:0] < IN_W'(lim));
  endfunction

  // item registers
  logic [2:0]             op_q;
  logic signed [IN_W-1:0] x_q, y_q;
  logic                   blk_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= op;
      x_q   <= x;
      y_q   <= y;
      blk_q <= cell_blocked;
    end
  end

  // tile grid size and cell-to-tile coordinates
  logic [DIM_W-1:0]   gw_up, gh_up;
  logic [PROD_W-1:0]  p_tw, p_th, p_cx, p_cy;
  logic [DIM_W-1:0]   tw_q, th_q;
  logic [COORD_W-1:0] ctx_q, cty_q;
  logic               cell_in_q;

  always_comb begin
    gw_up = geom.gw + DIM_W'(geom.ts) - DIM_W'(1);
    gh_up = geom.gh + DIM_W'(geom.ts) - DIM_W'(1);
    p_tw  = PROD_W'(gw_up) * PROD_W'(geom.rcp);
    p_th  = PROD_W'(gh_up) * PROD_W'(geom.rcp);
    p_cx  = PROD_W'(x_q[DIM_W-1:0]) * PROD_W'(geom.rcp);
    p_cy  = PROD_W'(y_q[DIM_W-1:0]) * PROD_W'(geom.rcp);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      tw_q      <= p_tw[RCP_SH +: DIM_W];
      th_q      <= p_th[RCP_SH +: DIM_W];
      ctx_q     <= p_cx[RCP_SH +: COORD_W];
      cty_q     <= p_cy[RCP_SH +: COORD_W];
      cell_in_q <= !x_q[IN_W-1] && (x_q[DIM_W-1:0] < geom.gw) &&
                   !y_q[IN_W-1] && (y_q[DIM_W-1:0] < geom.gh);
    end
  end

  // tile coordinate bounds
  logic [IN_W:0] xw, yw, xm1, xp1, ym1, yp1;
  logic          x_in, y_in, xm1_in, xp1_in, ym1_in, yp1_in, tile_in;

  always_comb begin
    xw      = {x_q[IN_W-1], x_q};
    yw      = {y_q[IN_W-1], y_q};
    xm1     = xw - (IN_W+1)'(1);
    xp1     = xw + (IN_W+1)'(1);
    ym1     = yw - (IN_W+1)'(1);
    yp1     = yw + (IN_W+1)'(1);
    x_in    = in_rng(xw, tw_q);
    y_in    = in_rng(yw, th_q);
    xm1_in  = in_rng(xm1, tw_q);
    xp1_in  = in_rng(xp1, tw_q);
    ym1_in  = in_rng(ym1, th_q);
    yp1_in  = in_rng(yp1, th_q);
    tile_in = x_in && y_in;
  end

  // tile rows; a row never written reads as all impassable
  logic [MAX_GRID_DIM-1:0] tile_mem [MAX_GRID_DIM];
  logic [MAX_GRID_DIM-1:0] row_vld;
  logic [MAX_GRID_DIM-1:0] rd_q, rd_row, wr_row;
  logic                    rd_ok_q;
  logic [COORD_W-1:0]      rd_addr;

  always_comb begin
    case (cmd.rd_sel)
      RD_CELL: rd_addr = cty_q;
      RD_UP:   rd_addr = ym1[COORD_W-1:0];
      RD_MID:  rd_addr = y_q[COORD_W-1:0];
      RD_DN:   rd_addr = yp1[COORD_W-1:0];
      default: rd_addr = y_q[COORD_W-1:0];
    endcase
    rd_row        = rd_ok_q ? rd_q : '0;
    wr_row        = rd_row;
    wr_row[ctx_q] = (op_q == OP_LOAD);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q <= tile_mem[rd_addr];
    end
    if (cmd.wr_en) begin
      tile_mem[cty_q] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_ok_q <= row_vld[rd_addr];
      end
      if (cmd.wr_en) begin
        row_vld[cty_q] <= 1'b1;
      end
    end
  end

  // query and neighbour bits
  logic       pass_q;
  logic [3:0] mask_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pass_q <= 1'b0;
      mask_q <= '0;
    end else if (cmd.cap_en) begin
      case (cmd.cap_sel)
        CAP_UP: begin
          mask_q[0] <= ym1_in && x_in && rd_row[x_q[COORD_W-1:0]];
        end
        CAP_MID: begin
          pass_q    <= tile_in && rd_row[x_q[COORD_W-1:0]];
          mask_q[2] <= xm1_in && y_in && rd_row[xm1[COORD_W-1:0]];
          mask_q[3] <= xp1_in && y_in && rd_row[xp1[COORD_W-1:0]];
        end
        CAP_DN: begin
          mask_q[1] <= yp1_in && x_in && rd_row[x_q[COORD_W-1:0]];
        end
        default: ;
      endcase
    end
  end

  // cell listing, column outer
  logic [LP_W-1:0]    xs_p, ys_p, xe_p, ye_p;
  logic [COORD_W-1:0] cx_q, cy_q, ys_q;
  logic [DIM_W-1:0]   xe_q, ye_q;
  logic               cx_end, cy_end;

  always_comb begin
    xs_p   = LP_W'(x_q[COORD_W-1:0]) * LP_W'(geom.ts);
    ys_p   = LP_W'(y_q[COORD_W-1:0]) * LP_W'(geom.ts);
    xe_p   = (LP_W'(x_q[COORD_W-1:0]) + LP_W'(1)) * LP_W'(geom.ts);
    ye_p   = (LP_W'(y_q[COORD_W-1:0]) + LP_W'(1)) * LP_W'(geom.ts);
    cx_end = (DIM_W'(cx_q) + DIM_W'(1)) >= xe_q;
    cy_end = (DIM_W'(cy_q) + DIM_W'(1)) >= ye_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.list_init) begin
      cx_q <= xs_p[COORD_W-1:0];
      cy_q <= ys_p[COORD_W-1:0];
      ys_q <= ys_p[COORD_W-1:0];
      xe_q <= (xe_p < LP_W'(geom.gw)) ? xe_p[DIM_W-1:0] : geom.gw;
      ye_q <= (ye_p < LP_W'(geom.gh)) ? ye_p[DIM_W-1:0] : geom.gh;
    end else if (cmd.out_load && cmd.out_kind == OUT_LIST) begin
      if (cy_end) begin
        cy_q <= ys_q;
        cx_q <= cx_q + COORD_W'(1);
      end else begin
        cy_q <= cy_q + COORD_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        OUT_QUERY: begin
          passable      <= pass_q;
          neighbor_mask <= '0;
          cell_x_out    <= '0;
          cell_y_out    <= '0;
          last          <= 1'b1;
        end
        OUT_NBR: begin
          passable      <= 1'b0;
          neighbor_mask <= mask_q;
          cell_x_out    <= '0;
          cell_y_out    <= '0;
          last          <= 1'b1;
        end
        OUT_LIST: begin
          passable      <= 1'b0;
          neighbor_mask <= '0;
          cell_x_out    <= cx_q;
          cell_y_out    <= cy_q;
          last          <= cx_end && cy_end;
        end
        default: begin
          passable      <= 1'b0;
          neighbor_mask <= '0;
          cell_x_out    <= '0;
          cell_y_out    <= '0;
          last          <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    stat.op        = op_q;
    stat.blocked   = blk_q;
    stat.cell_in   = cell_in_q;
    stat.tile_in   = tile_in;
    stat.out_free  = !out_valid || !out_stall;
    stat.list_last = cx_end && cy_end;
  end

endmodule

// ===== rtl/coarse_tile_passability_map_core.sv =====
// Coarse tile passability map: configuration registers, controller and datapath.
// One item at a time: in_stall holds off a new item until the last one is done.
// A list gives one cell per cycle while the result register is not stalled; query,
// neighbour and list results wait on result stalls, and rejected or unused ops return to idle.
// Row reads and writes share the single-port tile row memory.
// Synchronous reset: all tiles impassable (row valid bits), geometry 256 x 256, tile 4.
`timescale 1ns / 1ps
module coarse_tile_passability_map_core import cptm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             op,
  input  logic signed [IN_W-1:0] x,
  input  logic signed [IN_W-1:0] y,
  input  logic                   cell_blocked,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   passable,
  output logic [3:0]             neighbor_mask,
  output logic [COORD_W-1:0]     cell_x_out,
  output logic [COORD_W-1:0]     cell_y_out,
  output logic                   last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [DIM_W-1:0] grid_width, grid_height;
  logic [TS_W-1:0]  tile_size;
  logic [TS_W-1:0]  ts_e;
  geom_t            geom;
  cmd_t             cmd;
  stat_t            stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(MAX_GRID_DIM);
      grid_height <= DIM_W'(MAX_GRID_DIM);
      tile_size   <= TS_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_W: grid_width  <= cfg_data[DIM_W-1:0];
        CFG_GRID_H: grid_height <= cfg_data[DIM_W-1:0];
        CFG_TILE:   tile_size   <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range settings saturate
  always_comb begin
    ts_e = (tile_size == '0) ? TS_W'(1) :
           (tile_size > TS_W'(MAX_TILE_SIDE)) ? TS_W'(MAX_TILE_SIDE) : tile_size;
    geom.gw  = (grid_width == '0) ? DIM_W'(1) :
               (grid_width > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : grid_width;
    geom.gh  = (grid_height == '0) ? DIM_W'(1) :
               (grid_height > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : grid_height;
    geom.ts  = ts_e;
    geom.rcp = tile_rcp(ts_e);
  end

  cptm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cptm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .geom          (geom),
    .op            (op),
    .x             (x),
    .y             (y),
    .cell_blocked  (cell_blocked),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .passable      (passable),
    .neighbor_mask (neighbor_mask),
    .cell_x_out    (cell_x_out),
    .cell_y_out    (cell_y_out),
    .last          (last)
  );

endmodule

// ===== sim/coarse_tile_passability_map_core_tb.sv =====
// Self-checking testbench for coarse_tile_passability_map_core: tracks the tile bits and
// geometry alongside the block and checks every result item in order.
// Depends on cptm_pkg and the core RTL only.
`timescale 1ns / 1ps
module coarse_tile_passability_map_core_tb;
  import cptm_pkg::*;

  localparam int LIMIT = 400000;
  localparam int SETTLE = 12;
  localparam int STORE_DEPTH = MAX_GRID_DIM * MAX_GRID_DIM;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int DX [4] = '{0, 0, -1, 1};
  localparam int DY [4] = '{-1, 1, 0, 0};

  typedef struct packed {
    logic [2:0]             op;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic                   blocked;
  } tile_cmd_t;

  typedef struct packed {
    logic               passable;
    logic [3:0]         mask;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               last;
  } answer_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [2:0]             op = OP_LOAD;
  logic signed [IN_W-1:0] x = '0;
  logic signed [IN_W-1:0] y = '0;
  logic                   cell_blocked = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   passable;
  logic [3:0]             neighbor_mask;
  logic [COORD_W-1:0]     cell_x_out;
  logic [COORD_W-1:0]     cell_y_out;
  logic                   last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_GRID_W;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  tile_cmd_t   cmd_q [$];
  answer_t     answer_q [$];
  bit          tile_open [STORE_DEPTH];
  logic [8:0]  cur_gw = 9'd256;
  logic [8:0]  cur_gh = 9'd256;
  logic [3:0]  cur_ts = 4'd4;
  logic        in_took = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned issued = 0;
  logic        calm;

  // long stretch with no idling on either side
  assign calm = issued >= 100 && issued < 170;

  coarse_tile_passability_map_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int clamp_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > MAX_GRID_DIM) return MAX_GRID_DIM;
    return int'(v);
  endfunction

  function automatic int clamp_side(logic [3:0] v);
    if (v == 0) return 1;
    if (v > MAX_TILE_SIDE) return MAX_TILE_SIDE;
    return int'(v);
  endfunction

  function automatic int tile_index(int tx, int ty);
    return (ty * MAX_GRID_DIM + tx) % STORE_DEPTH;
  endfunction

  function automatic void track_tile_map(tile_cmd_t c);
    int gw, gh, ts, tw, th, xi, yi, nx, ny, d;
    int xs, ys, xe, ye, cx, cy, n, total;
    answer_t a;
    gw = clamp_dim(cur_gw);
    gh = clamp_dim(cur_gh);
    ts = clamp_side(cur_ts);
    tw = (gw + ts - 1) / ts;
    th = (gh + ts - 1) / ts;
    xi = $signed(c.x);
    yi = $signed(c.y);
    a = '0;
    a.last = 1'b1;
    case (c.op)
      OP_LOAD, OP_PREDICT: begin
        if (xi >= 0 && xi < gw && yi >= 0 && yi < gh) begin
          if (c.op == OP_PREDICT) tile_open[tile_index(xi / ts, yi / ts)] = 1'b0;
          else if (!c.blocked) tile_open[tile_index(xi / ts, yi / ts)] = 1'b1;
        end
      end
      OP_QUERY: begin
        a.passable = xi >= 0 && xi < tw && yi >= 0 && yi < th && tile_open[tile_index(xi, yi)];
        answer_q = {answer_q, a};
      end
      OP_NBR: begin
        for (d = 0; d < 4; d++) begin
          nx = xi + DX[d];
          ny = yi + DY[d];
          if (nx >= 0 && nx < tw && ny >= 0 && ny < th && tile_open[tile_index(nx, ny)])
            a.mask[d] = 1'b1;
        end
        answer_q = {answer_q, a};
      end
      OP_LIST: begin
        if (xi >= 0 && xi < tw && yi >= 0 && yi < th) begin
          xs = xi * ts;
          ys = yi * ts;
          xe = (xs + ts < gw) ? xs + ts : gw;
          ye = (ys + ts < gh) ? ys + ts : gh;
          total = (xe - xs) * (ye - ys);
          n = 0;
          for (cx = xs; cx < xe; cx++) begin
            for (cy = ys; cy < ye; cy++) begin
              n++;
              a = '0;
              a.cx = cx[COORD_W-1:0];
              a.cy = cy[COORD_W-1:0];
              a.last = (n == total);
              answer_q = {answer_q, a};
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic tile_cmd_t random_cmd();
    tile_cmd_t c;
    int r, gw, gh, ts, tw, th;
    gw = clamp_dim(cur_gw);
    gh = clamp_dim(cur_gh);
    ts = clamp_side(cur_ts);
    tw = (gw + ts - 1) / ts;
    th = (gh + ts - 1) / ts;
    r = $urandom_range(99);
    c.blocked = $urandom_range(99) < 35;
    if (r < 36) begin
      c.op = OP_LOAD;
      c.x = IN_W'($urandom_range(gw - 1));
      c.y = IN_W'($urandom_range(gh - 1));
    end else if (r < 46) begin
      c.op = OP_PREDICT;
      c.x = IN_W'($urandom_range(gw - 1));
      c.y = IN_W'($urandom_range(gh - 1));
    end else if (r < 64) begin
      c.op = OP_QUERY;
      c.x = IN_W'(int'($urandom_range(tw + 1)) - 1);
      c.y = IN_W'(int'($urandom_range(th + 1)) - 1);
    end else if (r < 82) begin
      c.op = OP_NBR;
      c.x = IN_W'(int'($urandom_range(tw + 1)) - 1);
      c.y = IN_W'(int'($urandom_range(th + 1)) - 1);
    end else if (r < 93) begin
      c.op = OP_LIST;
      c.x = ($urandom_range(9) == 0) ? IN_W'(tw) : IN_W'($urandom_range(tw - 1));
      c.y = IN_W'($urandom_range(th - 1));
    end else begin
      c.op = 3'($urandom_range(7));
      c.x = IN_W'($urandom);
      c.y = IN_W'($urandom);
    end
    return c;
  endfunction

  task automatic push(logic [2:0] o, int px, int py, logic b);
    tile_cmd_t c;
    c.op = o;
    c.x = IN_W'(px);
    c.y = IN_W'(py);
    c.blocked = b;
    cmd_q = {cmd_q, c};
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic quiesce();
    do @(posedge clk); while (cmd_q.size() != 0 || in_valid || answer_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    tile_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (cmd_q.size() == 0 || (!calm && $urandom_range(99) < 14)) begin
        in_valid <= 1'b0;
      end else begin
        c = cmd_q.pop_front();
        in_valid <= 1'b1;
        op <= c.op;
        x <= c.x;
        y <= c.y;
        cell_blocked <= c.blocked;
        issued++;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 14);
  end

  // monitor
  always @(posedge clk) begin
    answer_t got, want;
    tile_cmd_t c;
    cycles++;
    if (cycles >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      in_took <= in_valid && !in_stall && !rst;
      if (!rst) begin
        if (cfg_valid && cfg_ready) begin
          case (cfg_index)
            CFG_GRID_W: cur_gw = cfg_data;
            CFG_GRID_H: cur_gh = cfg_data;
            CFG_TILE:   cur_ts = cfg_data[3:0];
            default: begin
            end
          endcase
        end
        if (out_valid && !out_stall) begin
          got.passable = passable;
          got.mask = neighbor_mask;
          got.cx = cell_x_out;
          got.cy = cell_y_out;
          got.last = last;
          if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("unexpected item: pass=%0d mask=%h x=%0d y=%0d last=%0d",
                       got.passable, got.mask, got.cx, got.cy, got.last);
          end else begin
            want = answer_q.pop_front();
            if (got !== want) begin
              mismatches++;
              if (mismatches <= 10)
                $display("mismatch: exp pass=%0d mask=%h x=%0d y=%0d last=%0d, ",
                         want.passable, want.mask, want.cx, want.cy, want.last,
                         "got pass=%0d mask=%h x=%0d y=%0d last=%0d",
                         got.passable, got.mask, got.cx, got.cy, got.last);
            end
          end
        end
        if (in_valid && !in_stall) begin
          c.op = op;
          c.x = x;
          c.y = y;
          c.blocked = cell_blocked;
          track_tile_map(c);
        end
      end
    end
  end

  initial begin
    int p, k;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry: 256 x 256, tile 4
    push(OP_QUERY, 0, 0, 1'b0);
    push(OP_LOAD, 0, 0, 1'b0);
    push(OP_QUERY, 0, 0, 1'b0);
    push(OP_LOAD, 5, 5, 1'b1);
    push(OP_QUERY, 1, 1, 1'b0);
    push(OP_LOAD, 255, 255, 1'b0);
    push(OP_NBR, 63, 62, 1'b0);
    push(OP_LOAD, 6, 1, 1'b0);
    push(OP_NBR, 0, 0, 1'b0);
    push(OP_PREDICT, 3, 3, 1'b0);
    push(OP_PREDICT, 256, 0, 1'b0);
    push(OP_LOAD, -1, 0, 1'b0);
    push(OP_LOAD, 0, -512, 1'b0);
    push(OP_QUERY, -512, 511, 1'b0);
    push(OP_QUERY, 64, 0, 1'b0);
    push(OP_LIST, 0, 0, 1'b0);
    push(OP_LIST, 63, 63, 1'b0);
    push(OP_LIST, 64, 0, 1'b0);
    push(3'd5, 0, 0, 1'b0);
    push(3'd7, 1, 1, 1'b1);
    quiesce();

    // clipped edge tiles
    write_reg(CFG_GRID_W, 10);
    write_reg(CFG_GRID_H, 7);
    write_reg(CFG_TILE, 3);
    push(OP_LIST, 3, 2, 1'b0);
    push(OP_NBR, 3, 1, 1'b0);
    quiesce();

    // zero sizes act as one, oversize height clamps
    write_reg(CFG_GRID_W, 0);
    write_reg(CFG_GRID_H, 511);
    write_reg(CFG_TILE, 0);
    write_reg(CFG_SPARE, 511);
    push(OP_LIST, 0, 255, 1'b0);
    quiesce();

    write_reg(CFG_GRID_W, 300);
    write_reg(CFG_GRID_H, 1);
    write_reg(CFG_TILE, 15);
    push(OP_LIST, 31, 0, 1'b0);
    push(OP_QUERY, 31, 0, 1'b0);

    for (p = 0; p < 5; p++) begin
      quiesce();
      if (p == 0) begin
        write_reg(CFG_GRID_W, 256);
        write_reg(CFG_GRID_H, 256);
        write_reg(CFG_TILE, 8);
      end else begin
        write_reg(CFG_GRID_W,
                  ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 40));
        write_reg(CFG_GRID_H,
                  ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 40));
        write_reg(CFG_TILE,
                  ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8));
      end
      for (k = 0; k < 56; k++) cmd_q = {cmd_q, random_cmd()};
    end
    quiesce();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
